// ===== rtl/rtp2c_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the radar
// track polar-to-Cartesian converter. No dependencies.
package rtp2c_pkg;

  localparam int TrackSlotsDef    = 64;
  localparam int SlotsPerGroupDef = 7;
  localparam int CordicStagesDef  = 16;

  localparam int FullGroups = 9;
  localparam int LastGroup  = 9;

  localparam int CW = 34;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_POWER = 2'd1;
  localparam logic [1:0] REQ_TRACK = 2'd2;

  localparam logic signed [22:0] DecidegToQ30 = 23'sd1874033;
  localparam logic signed [CW-1:0] CordicGainQ30 = 34'sd652032874;
  localparam logic [5:0] RcsOffset = 6'd10;

  localparam logic signed [19:0] PosMin = -20'sd20480;
  localparam logic signed [19:0] PosMax = 20'sd20479;
  localparam logic signed [19:0] VelMin = -20'sd16384;
  localparam logic signed [19:0] VelMax = 20'sd16383;

  typedef struct packed {
    logic [5:0]             idx;
    logic [14:0]            r10;
    logic signed [13:0]     rr;
    logic signed [10:0]     lat;
    logic signed [5:0]      cs;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [CW-1:0]   z;
  } trk_t;

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] a;
    case (i)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021687;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048576;
      11: a = 34'sd524288;
      12: a = 34'sd262144;
      13: a = 34'sd131072;
      14: a = 34'sd65536;
      15: a = 34'sd32768;
      16: a = 34'sd16384;
      17: a = 34'sd8192;
      18: a = 34'sd4096;
      19: a = 34'sd2048;
      20: a = 34'sd1024;
      21: a = 34'sd512;
      22: a = 34'sd256;
      23: a = 34'sd128;
      24: a = 34'sd64;
      25: a = 34'sd32;
      26: a = 34'sd16;
      27: a = 34'sd8;
      28: a = 34'sd4;
      29: a = 34'sd2;
      30: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/radar_track_polar_to_cartesian_top.sv =====
// Top level of the radar track polar-to-Cartesian converter.
// Depends on rtp2c_pkg, rtp2c_power_table, rtp2c_cordic_stage, rtp2c_mix.
//
// Input channel (in_valid_i/in_ready_o) carries one request per transfer:
// clear the power table, write one power entry, or a track report. Only a
// track report with nonzero status produces a transfer on the output channel
// (out_valid_o/out_ready_i); other requests take effect at their transfer.
// The result passes through CORDIC_STAGES + 3 register stages (capture with table
// read at the transfer edge, one register per CORDIC micro-rotation, one product
// stage, one round/saturate output register). Throughput is one request per cycle
// while the receiver does not stall. The pipeline advances as a whole when the
// output register is empty or being taken; while the receiver stalls the whole
// pipeline holds and in_ready_o is low, nothing is dropped.
// Reset clears all pipeline valid bits and marks every power entry as zero;
// a clear request does the same for the table.
module radar_track_polar_to_cartesian_top #(
  parameter int TRACK_SLOTS     = rtp2c_pkg::TrackSlotsDef,
  parameter int SLOTS_PER_GROUP = rtp2c_pkg::SlotsPerGroupDef,
  parameter int CORDIC_STAGES   = rtp2c_pkg::CordicStagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         power_group_i,
  input  logic [2:0]         power_slot_i,
  input  logic [4:0]         power_value_i,
  input  logic [5:0]         track_index_i,
  input  logic [2:0]         track_status_i,
  input  logic [10:0]        track_range_i,
  input  logic signed [9:0]  track_angle_i,
  input  logic signed [13:0] track_range_rate_i,
  input  logic signed [5:0]  track_lateral_rate_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         obstacle_id_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [14:0] vel_x_o,
  output logic signed [14:0] vel_y_o,
  output logic signed [5:0]  cross_section_o
);
  import rtp2c_pkg::*;

  logic en;
  logic accept;
  logic signed [5:0] cs;

  logic s0_valid_q;
  logic [5:0]        s0_idx_q;
  logic [14:0]       s0_r10_q;
  logic signed [13:0] s0_rr_q;
  logic signed [10:0] s0_lat_q;
  logic signed [CW-1:0] s0_z_q;

  logic v_s [CORDIC_STAGES+1];
  trk_t d_s [CORDIC_STAGES+1];

  assign en     = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign accept = in_valid_i && en;

  rtp2c_power_table #(
    .TRACK_SLOTS    (TRACK_SLOTS),
    .SLOTS_PER_GROUP(SLOTS_PER_GROUP)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_type_i   (req_type_i),
    .power_group_i(power_group_i),
    .power_slot_i (power_slot_i),
    .power_value_i(power_value_i),
    .track_index_i(track_index_i),
    .cs_o         (cs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= accept && (req_type_i == REQ_TRACK) && (track_status_i != 3'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_idx_q <= track_index_i;
      s0_r10_q <= 15'(track_range_i) * 15'd10;
      s0_rr_q  <= track_range_rate_i;
      s0_lat_q <= 11'(track_lateral_rate_i) * 11'sd25;
      s0_z_q   <= CW'(track_angle_i) * CW'(DecidegToQ30);
    end
  end

  always_comb begin
    v_s[0]     = s0_valid_q;
    d_s[0].idx = s0_idx_q;
    d_s[0].r10 = s0_r10_q;
    d_s[0].rr  = s0_rr_q;
    d_s[0].lat = s0_lat_q;
    d_s[0].cs  = cs;
    d_s[0].x   = CordicGainQ30;
    d_s[0].y   = '0;
    d_s[0].z   = s0_z_q;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    rtp2c_cordic_stage #(.STAGE_IDX(g)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(v_s[g]),
      .data_i (d_s[g]),
      .valid_o(v_s[g+1]),
      .data_o (d_s[g+1])
    );
  end

  rtp2c_mix u_mix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (v_s[CORDIC_STAGES]),
    .data_i         (d_s[CORDIC_STAGES]),
    .valid_o        (out_valid_o),
    .obstacle_id_o  (obstacle_id_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .vel_x_o        (vel_x_o),
    .vel_y_o        (vel_y_o),
    .cross_section_o(cross_section_o)
  );

  a_no_result_for_non_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i != REQ_TRACK) |=> !s0_valid_q)
    else $error("non-track request entered the pipeline");

  a_no_result_for_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (track_status_i == 3'd0) |=> !s0_valid_q)
    else $error("no-target track entered the pipeline");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(s0_valid_q) && $stable(out_valid_o))
    else $error("pipeline moved during stall");

  a_cs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cross_section_o >= -6'sd10) && (cross_section_o <= 6'sd21))
    else $error("cross section out of range");

endmodule

// ===== rtl/rtp2c_power_table.sv =====
// Motion-power table: one write port, one registered read port, valid bits
// per entry so a clear resets only the valid bits. Depends on rtp2c_pkg.
module rtp2c_power_table #(
  parameter int TRACK_SLOTS     = rtp2c_pkg::TrackSlotsDef,
  parameter int SLOTS_PER_GROUP = rtp2c_pkg::SlotsPerGroupDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] req_type_i,
  input  logic [3:0] power_group_i,
  input  logic [2:0] power_slot_i,
  input  logic [4:0] power_value_i,
  input  logic [5:0] track_index_i,
  output logic signed [5:0] cs_o
);
  import rtp2c_pkg::*;

  localparam int AW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;

  logic [4:0] mem [TRACK_SLOTS];
  logic [TRACK_SLOTS-1:0] vld_q;
  logic [4:0] rd_q;
  logic       rv_q;

  logic [8:0] wr_addr;
  logic [8:0] rd_addr;
  logic       wr_ok;
  logic       rd_ok;
  logic       wr_en;

  assign wr_addr = 9'(power_group_i) * 9'(SLOTS_PER_GROUP) + 9'(power_slot_i);
  assign rd_addr = 9'(track_index_i);
  assign wr_ok = (int'(power_group_i) < FullGroups) ?
                 (int'(power_slot_i) < SLOTS_PER_GROUP) :
                 ((int'(power_group_i) == LastGroup) && (power_slot_i == 3'd0));
  assign wr_en = accept_i && (req_type_i == REQ_POWER) && wr_ok &&
                 (int'(wr_addr) < TRACK_SLOTS);
  assign rd_ok = int'(rd_addr) < TRACK_SLOTS;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= power_value_i;
    end
    if (accept_i && rd_ok) begin
      rd_q <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else if (accept_i) begin
      rv_q <= rd_ok && vld_q[rd_addr[AW-1:0]];
      if (req_type_i == REQ_CLEAR) begin
        vld_q <= '0;
      end else if (wr_en) begin
        vld_q[wr_addr[AW-1:0]] <= 1'b1;
      end
    end
  end

  assign cs_o = signed'((rv_q ? {1'b0, rd_q} : 6'd0) - RcsOffset);

endmodule

// ===== rtl/rtp2c_cordic_stage.sv =====
// One registered rotation-mode CORDIC micro-rotation.
// Depends on rtp2c_pkg.
module rtp2c_cordic_stage #(
  parameter int STAGE_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  rtp2c_pkg::trk_t  data_i,
  output logic             valid_o,
  output rtp2c_pkg::trk_t  data_o
);
  import rtp2c_pkg::*;

  trk_t data_d;
  trk_t data_q;
  logic valid_q;

  always_comb begin
    data_d = data_i;
    if (!data_i.z[CW-1]) begin
      data_d.x = data_i.x - (data_i.y >>> STAGE_IDX);
      data_d.y = data_i.y + (data_i.x >>> STAGE_IDX);
      data_d.z = data_i.z - atan_q30(STAGE_IDX);
    end else begin
      data_d.x = data_i.x + (data_i.y >>> STAGE_IDX);
      data_d.y = data_i.y - (data_i.x >>> STAGE_IDX);
      data_d.z = data_i.z + atan_q30(STAGE_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/rtp2c_mix.sv =====
// Product stage and round/saturate output stage for position and velocity.
// Depends on rtp2c_pkg.
module rtp2c_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  rtp2c_pkg::trk_t    data_i,
  output logic               valid_o,
  output logic [5:0]         obstacle_id_o,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [14:0] vel_x_o,
  output logic signed [14:0] vel_y_o,
  output logic signed [5:0]  cross_section_o
);
  import rtp2c_pkg::*;

  localparam int PW = 52;

  logic              m_valid_q;
  logic [5:0]        m_idx_q;
  logic signed [5:0] m_cs_q;
  logic signed [PW-1:0] m_pxc_q, m_pys_q, m_rrc_q, m_rrs_q, m_lac_q, m_las_q;

  logic signed [PW-1:0] r10_s, rr_s, lat_s, cx, sy;
  logic signed [PW-1:0] vx_sum, vy_sum;
  logic signed [19:0] px_r, py_r, vx_r, vy_r;

  logic              o_valid_q;
  logic [5:0]        o_idx_q;
  logic signed [5:0] o_cs_q;
  logic signed [15:0] o_px_q, o_py_q;
  logic signed [14:0] o_vx_q, o_vy_q;

  function automatic logic signed [19:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + (PW'(1) <<< 29)) >>> 30;
    return t[19:0];
  endfunction

  function automatic logic signed [19:0] sat(input logic signed [19:0] v,
                                             input logic signed [19:0] lo,
                                             input logic signed [19:0] hi);
    logic signed [19:0] r;
    r = (v < lo) ? lo : ((v > hi) ? hi : v);
    return r;
  endfunction

  assign r10_s = PW'(signed'({1'b0, data_i.r10}));
  assign rr_s  = PW'(data_i.rr);
  assign lat_s = PW'(data_i.lat);
  assign cx    = PW'(data_i.x);
  assign sy    = PW'(data_i.y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en_i) begin
      m_valid_q <= valid_i;
      o_valid_q <= m_valid_q;
    end
  end

  assign vx_sum = m_rrc_q - m_las_q;
  assign vy_sum = m_rrs_q + m_lac_q;
  assign px_r = sat(rnd(m_pxc_q), PosMin, PosMax);
  assign py_r = sat(rnd(m_pys_q), PosMin, PosMax);
  assign vx_r = sat(rnd(vx_sum), VelMin, VelMax);
  assign vy_r = sat(rnd(vy_sum), VelMin, VelMax);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_idx_q <= data_i.idx;
      m_cs_q  <= data_i.cs;
      m_pxc_q <= r10_s * cx;
      m_pys_q <= r10_s * sy;
      m_rrc_q <= rr_s * cx;
      m_rrs_q <= rr_s * sy;
      m_lac_q <= lat_s * cx;
      m_las_q <= lat_s * sy;
      o_idx_q <= m_idx_q;
      o_cs_q  <= m_cs_q;
      o_px_q  <= px_r[15:0];
      o_py_q  <= py_r[15:0];
      o_vx_q  <= vx_r[14:0];
      o_vy_q  <= vy_r[14:0];
    end
  end

  assign valid_o         = o_valid_q;
  assign obstacle_id_o   = o_idx_q;
  assign pos_x_o         = o_px_q;
  assign pos_y_o         = o_py_q;
  assign vel_x_o         = o_vx_q;
  assign vel_y_o         = o_vy_q;
  assign cross_section_o = o_cs_q;

endmodule

// ===== dv/tb_radar_track_polar_to_cartesian_top.sv =====
// Testbench for the radar track polar-to-Cartesian converter: drives clear,
// power, unknown-type and track requests with random gaps and checks every obstacle
// against a bit-exact CORDIC predictor. Depends on rtp2c_pkg and the top module.
module tb_radar_track_polar_to_cartesian_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rtp2c_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct {
    logic [5:0]         id;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [14:0] vx;
    logic signed [14:0] vy;
    logic signed [5:0]  cs;
  } obstacle_t;

  class obstacle_board;
    logic [4:0] motion_power[64];
    obstacle_t  pending[$];
    int         errors;

    function new();
      foreach (motion_power[i]) motion_power[i] = '0;
      errors = 0;
    endfunction

    function longint round_sat(longint v, longint lo, longint hi);
      longint r;
      r = (v + (64'sd1 <<< 29)) >>> 30;
      return r < lo ? lo : (r > hi ? hi : r);
    endfunction

    function void note_request(logic [1:0] kind, logic [3:0] grp, logic [2:0] slot,
                               logic [4:0] pwr, logic [5:0] idx, logic [2:0] status,
                               logic [10:0] rng, logic signed [9:0] ang,
                               logic signed [13:0] rr, logic signed [5:0] lat);
      longint x, y, z, dx, dy, r10, rrl, latl, lim, addr;
      obstacle_t o;
      if (kind == REQ_CLEAR) begin
        foreach (motion_power[i]) motion_power[i] = '0;
      end else if (kind == REQ_POWER) begin
        lim = (grp < FullGroups) ? 7 : 1;
        addr = grp * 7 + slot;
        if (grp <= LastGroup && slot < lim && addr < 64) motion_power[addr] = pwr;
      end else if (kind == REQ_TRACK && status != 0) begin
        x = 652032874;
        y = 0;
        z = longint'(ang) * 1874033;
        for (int i = 0; i < 16; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_q30(i));
          end else begin
            x += dx; y -= dy; z += longint'(atan_q30(i));
          end
        end
        r10 = longint'(rng) * 10;
        rrl = longint'(rr);
        latl = longint'(lat) * 25;
        o.id = idx;
        o.px = round_sat(r10 * x, -20480, 20479);
        o.py = round_sat(r10 * y, -20480, 20479);
        o.vx = round_sat(rrl * x - latl * y, -16384, 16383);
        o.vy = round_sat(rrl * y + latl * x, -16384, 16383);
        o.cs = $signed({1'b0, motion_power[idx]}) - 6'sd10;
        pending.push_back(o);
      end
    endfunction

    function void check_obstacle(obstacle_t a);
      obstacle_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected obstacle id %0d", $time, a.id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.id !== e.id || a.px !== e.px || a.py !== e.py || a.vx !== e.vx ||
          a.vy !== e.vy || a.cs !== e.cs) begin
        $display("%0t mismatch exp id=%0d x=%0d y=%0d vx=%0d vy=%0d cs=%0d", $time,
                 e.id, e.px, e.py, e.vx, e.vy, e.cs);
        $display("%0t          act id=%0d x=%0d y=%0d vx=%0d vy=%0d cs=%0d", $time,
                 a.id, a.px, a.py, a.vx, a.vy, a.cs);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_ready_o, out_valid_o, out_ready_i = 0;
  logic [1:0] req_type_i = 0;
  logic [3:0] power_group_i = 0;
  logic [2:0] power_slot_i = 0;
  logic [4:0] power_value_i = 0;
  logic [5:0] track_index_i = 0;
  logic [2:0] track_status_i = 0;
  logic [10:0] track_range_i = 0;
  logic signed [9:0] track_angle_i = 0;
  logic signed [13:0] track_range_rate_i = 0;
  logic signed [5:0] track_lateral_rate_i = 0;
  logic [5:0] obstacle_id_o;
  logic signed [15:0] pos_x_o, pos_y_o;
  logic signed [14:0] vel_x_o, vel_y_o;
  logic signed [5:0] cross_section_o;

  obstacle_board board = new();
  bit stim_done = 0;
  bit hold_full = 0;
  int idle_cycles = 0;

  radar_track_polar_to_cartesian_top uut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    obstacle_t a;
    if (out_valid_o && out_ready_i) begin
      a.id = obstacle_id_o; a.px = pos_x_o; a.py = pos_y_o;
      a.vx = vel_x_o; a.vy = vel_y_o; a.cs = cross_section_o;
      board.check_obstacle(a);
    end
  end

  // receiver: random stalls, with calm stretches
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = hold_full ? 0 : $urandom_range(0, 11);
      if (n == 0) begin
        out_ready_i <= 1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= 0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send(logic [1:0] kind, logic [3:0] grp, logic [2:0] slot,
                      logic [4:0] pwr, logic [5:0] idx, logic [2:0] status,
                      logic [10:0] rng, logic [9:0] ang, logic [13:0] rr,
                      logic [5:0] lat, bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 11) : 0;
    if (n > 0) begin
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1;
    req_type_i <= kind; power_group_i <= grp; power_slot_i <= slot;
    power_value_i <= pwr; track_index_i <= idx; track_status_i <= status;
    track_range_i <= rng; track_angle_i <= ang; track_range_rate_i <= rr;
    track_lateral_rate_i <= lat;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(kind, grp, slot, pwr, idx, status, rng, ang, rr, lat);
  endtask

  task automatic send_track(logic [5:0] idx, logic [2:0] status, logic [10:0] rng,
                            logic [9:0] ang, logic [13:0] rr, logic [5:0] lat, bit gaps);
    send(REQ_TRACK, 4'($urandom), 3'($urandom), 5'($urandom), idx, status, rng, ang,
         rr, lat, gaps);
  endtask

  task automatic send_random(bit gaps);
    int k;
    k = $urandom_range(0, 99);
    if (k < 3)
      send(REQ_CLEAR, 4'($urandom), 3'($urandom), 5'($urandom), 6'($urandom),
           3'($urandom), 11'($urandom), 10'($urandom), 14'($urandom), 6'($urandom),
           gaps);
    else if (k < 5)
      send(REQ_UNKNOWN, 4'($urandom), 3'($urandom), 5'($urandom), 6'($urandom),
           3'($urandom), 11'($urandom), 10'($urandom), 14'($urandom), 6'($urandom),
           gaps);
    else if (k < 35)
      send(REQ_POWER, 4'($urandom_range(0, 15)), 3'($urandom), 5'($urandom),
           6'($urandom), 3'($urandom), 11'($urandom), 10'($urandom), 14'($urandom),
           6'($urandom), gaps);
    else
      send_track(6'($urandom), ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom),
                 11'($urandom), 10'($urandom), 14'($urandom), 6'($urandom), gaps);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_track(6'd63, 3'd1, 11'd2047, 10'h200, 14'h2000, 6'h20, 1);
    send_track(6'd0, 3'd7, 11'd2047, 10'h1ff, 14'h1fff, 6'h1f, 1);
    send_track(6'd5, 3'd0, 11'd100, 10'd0, 14'd0, 6'd0, 1);
    send_track(6'd1, 3'd2, 11'd0, 10'd0, 14'd0, 6'd0, 1);
    send_track(6'd2, 3'd3, 11'd1000, 10'd900, 14'd5000, 6'd31, 1);
    send_track(6'd3, 3'd4, 11'd1000, -10'sd450, -14'sd5000, -6'sd32, 1);
    send(REQ_POWER, 4'd0, 3'd0, 5'd31, 0, 0, 0, 0, 0, 0, 1);
    send(REQ_POWER, 4'd8, 3'd6, 5'd17, 0, 0, 0, 0, 0, 0, 1);
    send(REQ_POWER, 4'd9, 3'd0, 5'd21, 0, 0, 0, 0, 0, 0, 1);
    send(REQ_POWER, 4'd9, 3'd1, 5'd5, 0, 0, 0, 0, 0, 0, 1);
    send(REQ_POWER, 4'd3, 3'd7, 5'd5, 0, 0, 0, 0, 0, 0, 1);
    send(REQ_POWER, 4'd15, 3'd0, 5'd5, 0, 0, 0, 0, 0, 0, 1);
    send_track(6'd0, 3'd1, 11'd500, 10'd300, 14'd100, 6'd4, 1);
    send_track(6'd62, 3'd1, 11'd500, -10'sd300, 14'd100, 6'd4, 1);
    send_track(6'd63, 3'd1, 11'd500, 10'd0, 14'd100, 6'd4, 1);
    send(REQ_UNKNOWN, 0, 0, 0, 6'd1, 3'd1, 11'd5, 0, 0, 0, 1);
    send(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    send_track(6'd0, 3'd1, 11'd500, 10'd300, 14'd100, 6'd4, 1);
    for (int i = 0; i < 600; i++) begin
      if (i % 150 == 100) hold_full = 1;
      if (i % 150 == 130) hold_full = 0;
      send_random(!hold_full);
    end
    in_valid_i <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
